@@ hdl/chacha20_stream_xor_unit_defines.svh @@
// ----------------------------------------------------------------------------
// chacha20_stream_xor_unit assertion macros
// Shared concurrent assertion forms used across the cipher unit.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_UNIT_DEFINES_SVH
`define CHACHA20_STREAM_XOR_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define CCX_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CCX_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCX_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ccx_pkg.sv @@
// ----------------------------------------------------------------------------
// ccx_pkg
// Types, constants and helper functions shared by the cipher unit.
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int NUM_WORDS   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef logic [31:0] word_t;
  typedef word_t [NUM_WORDS-1:0] block_t;

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0     = 3'd0,
    CFG_KEY1     = 3'd1,
    CFG_KEY2     = 3'd2,
    CFG_KEY3     = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5,
    CFG_INIT_CNT = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ROUND,
    SEQ_FEED,
    SEQ_EMIT
  } seq_state_t;

  // Reordering of the entries within each state row, applied as a quarter-round completes.
  typedef enum logic [1:0] {
    PERM_NONE,
    PERM_ROW,
    PERM_DIAG,
    PERM_UNDIAG
  } perm_t;

  typedef struct packed {
    logic       load;
    logic       step_en;
    logic [1:0] step;
    perm_t      perm;
    logic       ff_en;
    logic [3:0] ff_idx;
  } ctrl_t;

  typedef struct packed {
    logic idle;
    logic emit;
  } stat_t;

  function automatic logic [4:0] rot_amt(logic [1:0] step);
    logic [4:0] amt;
    case (step)
      2'd0:    amt = 5'd16;
      2'd1:    amt = 5'd12;
      2'd2:    amt = 5'd8;
      default: amt = 5'd7;
    endcase
    return amt;
  endfunction

  function automatic word_t rotl(word_t v, logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

endpackage

@@ hdl/ccx_in_if.sv @@
// ----------------------------------------------------------------------------
// ccx_in_if
// Input channel: one message byte and its end-of-message flag per word.
// ----------------------------------------------------------------------------
interface ccx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

@@ hdl/ccx_out_if.sv @@
// ----------------------------------------------------------------------------
// ccx_out_if
// Result channel: one enciphered byte and its end-of-message flag per word.
// ----------------------------------------------------------------------------
interface ccx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

@@ hdl/chacha20_stream_xor_unit.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_xor_unit
// ChaCha20 keystream generator and byte-wise XOR for a streamed message.
//
// Each input word carries one message byte and a flag for the final byte;
// each result word carries that byte XORed with the keystream byte at the
// same message offset, plus the copied flag. A byte at offset 0 of a
// 64-byte block first builds that block: one shared add-xor-rotate unit
// performs one quarter-round step per cycle, then a feed-forward pass adds
// the start words; later bytes of the block reuse it. One byte is in
// flight at a time; the input is ready again once its result sits in
// the output register. Configuration must be written only while the unit
// is idle; the unit itself does not enforce this. Writing the initial
// counter also restarts the message.
// ----------------------------------------------------------------------------
`include "chacha20_stream_xor_unit_defines.svh"

module chacha20_stream_xor_unit
  import ccx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ccx_in_if.sink                in_ch,
  ccx_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [63:0]      key_r [4];
  logic [63:0]      nonce_lo_r;
  logic [31:0]      nonce_hi_r;
  word_t            init_cnt_r;

  // Message position: block counter and byte offset within the block.
  word_t            blk_cnt_r;
  logic [POS_W-1:0] pos_r;

  // Word held while its keystream is produced.
  logic [7:0]       item_byte_r;
  logic             item_last_r;

  // Output register.
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_valid_r;

  logic             in_accept;
  logic             start_gen;
  logic             start_emit;
  logic             out_free;
  block_t           start_words;
  block_t           ks_words;
  word_t            ks_word;
  word_t            ks_shift;
  ctrl_t            seq_ctrl;
  stat_t            seq_stat;

  assign in_ch.ready = seq_stat.idle;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign start_gen   = in_accept && (pos_r == '0);
  assign start_emit  = in_accept && (pos_r != '0);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Block input: constants, key, counter, nonce, little-endian words.
  always_comb begin
    start_words[0]  = SIGMA0;
    start_words[1]  = SIGMA1;
    start_words[2]  = SIGMA2;
    start_words[3]  = SIGMA3;
    start_words[4]  = key_r[0][31:0];
    start_words[5]  = key_r[0][63:32];
    start_words[6]  = key_r[1][31:0];
    start_words[7]  = key_r[1][63:32];
    start_words[8]  = key_r[2][31:0];
    start_words[9]  = key_r[2][63:32];
    start_words[10] = key_r[3][31:0];
    start_words[11] = key_r[3][63:32];
    start_words[12] = blk_cnt_r;
    start_words[13] = nonce_lo_r[31:0];
    start_words[14] = nonce_lo_r[63:32];
    start_words[15] = nonce_hi_r;
  end

  ccx_seq #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_gen  (start_gen),
    .start_emit (start_emit),
    .out_free   (out_free),
    .ctrl       (seq_ctrl),
    .stat       (seq_stat)
  );

  ccx_state u_state (
    .clk         (clk),
    .ctrl        (seq_ctrl),
    .start_words (start_words),
    .ks_words    (ks_words)
  );

  // Keystream bytes are taken little-endian from each state entry.
  assign ks_word  = ks_words[pos_r[POS_W-1:2]];
  assign ks_shift = ks_word >> {pos_r[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_byte_r <= in_ch.in_byte;
      item_last_r <= in_ch.last_byte;
    end
    if (seq_stat.emit) begin
      out_byte_r <= item_byte_r ^ ks_shift[7:0];
      out_last_r <= item_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_stat.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  // Configuration writes take priority; writing the initial counter
  // restarts the message at that counter value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      init_cnt_r <= '0;
      blk_cnt_r  <= '0;
      pos_r      <= '0;
    end else begin
      if (seq_stat.emit) begin
        if (item_last_r) begin
          pos_r     <= '0;
          blk_cnt_r <= init_cnt_r;
        end else begin
          pos_r <= pos_r + POS_W'(1);
          if (&pos_r) begin
            blk_cnt_r <= blk_cnt_r + 32'd1;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KEY0:     key_r[0]   <= cfg_wdata;
          CFG_KEY1:     key_r[1]   <= cfg_wdata;
          CFG_KEY2:     key_r[2]   <= cfg_wdata;
          CFG_KEY3:     key_r[3]   <= cfg_wdata;
          CFG_NONCE_LO: nonce_lo_r <= cfg_wdata;
          CFG_NONCE_HI: nonce_hi_r <= cfg_wdata[31:0];
          CFG_INIT_CNT: begin
            init_cnt_r <= cfg_wdata[31:0];
            blk_cnt_r  <= cfg_wdata[31:0];
            pos_r      <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  `CCX_ASSERT_NEXT(a_new_block_busy, clk, rst_n, in_accept && (pos_r == '0), !seq_stat.idle, "block generation did not start")
  `CCX_ASSERT_NEXT(a_emit_fills_output, clk, rst_n, seq_stat.emit, out_valid_r, "result not registered after emit")
  `CCX_ASSERT_NEXT(a_last_restarts, clk, rst_n, seq_stat.emit && item_last_r, (pos_r == '0) && (blk_cnt_r == init_cnt_r), "message did not restart after final byte")

endmodule

@@ hdl/ccx_alu.sv @@
// ----------------------------------------------------------------------------
// ccx_alu
// Shared add, xor and rotate unit: one quarter-round step per cycle.
// ----------------------------------------------------------------------------
module ccx_alu
  import ccx_pkg::*;
(
  input  word_t      a_in,
  input  word_t      b_in,
  input  word_t      d_in,
  input  logic [4:0] rot_in,
  output word_t      sum_out,
  output word_t      mix_out
);

  assign sum_out = a_in + b_in;
  assign mix_out = rotl(d_in ^ sum_out, rot_in);

endmodule

@@ hdl/ccx_state.sv @@
// ----------------------------------------------------------------------------
// ccx_state
// The sixteen 32-bit state registers with fixed taps into the shared unit.
// ----------------------------------------------------------------------------
module ccx_state
  import ccx_pkg::*;
(
  input  logic   clk,
  input  ctrl_t  ctrl,
  input  block_t start_words,
  output block_t ks_words
);

  block_t     w_r;
  block_t     w_nxt;
  word_t      alu_a;
  word_t      alu_b;
  word_t      alu_d;
  word_t      alu_sum;
  word_t      alu_mix;
  logic [4:0] alu_rot;

  // Rotate rows left by a per-row amount set by the kind; the quarter-round always works on column 0.
  function automatic block_t permute(block_t w, perm_t kind);
    block_t     p;
    logic [1:0] sh;
    logic [1:0] col;
    logic [3:0] src;
    p = w;
    for (int r = 0; r < 4; r++) begin
      case (kind)
        PERM_ROW:    sh = 2'd1;
        PERM_DIAG:   sh = 2'(r + 1);
        PERM_UNDIAG: sh = 2'(5 - r);
        default:     sh = 2'd0;
      endcase
      for (int j = 0; j < 4; j++) begin
        col = 2'(j) + sh;
        src = {2'(r), col};
        p[r*4+j] = w[src];
      end
    end
    return p;
  endfunction

  always_comb begin
    alu_rot = rot_amt(ctrl.step);
    alu_d   = ctrl.step[0] ? w_r[4] : w_r[12];
    if (ctrl.ff_en) begin
      alu_a = w_r[0];
      alu_b = start_words[ctrl.ff_idx];
    end else begin
      alu_a = ctrl.step[0] ? w_r[8]  : w_r[0];
      alu_b = ctrl.step[0] ? w_r[12] : w_r[4];
    end
  end

  ccx_alu u_alu (
    .a_in    (alu_a),
    .b_in    (alu_b),
    .d_in    (alu_d),
    .rot_in  (alu_rot),
    .sum_out (alu_sum),
    .mix_out (alu_mix)
  );

  always_comb begin
    w_nxt = w_r;
    if (ctrl.load) begin
      w_nxt = start_words;
    end else if (ctrl.step_en) begin
      if (ctrl.step[0]) begin
        w_nxt[8] = alu_sum;
        w_nxt[4] = alu_mix;
      end else begin
        w_nxt[0]  = alu_sum;
        w_nxt[12] = alu_mix;
      end
      if (ctrl.perm != PERM_NONE) begin
        w_nxt = permute(w_nxt, ctrl.perm);
      end
    end else if (ctrl.ff_en) begin
      // Feed-forward: shift down and append the sum, so once all sixteen entries
      // have passed, every entry holds its working value plus its start value.
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[NUM_WORDS-1] = alu_sum;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  assign ks_words = w_r;

endmodule

@@ hdl/ccx_seq.sv @@
// ----------------------------------------------------------------------------
// ccx_seq
// Sequencer: round, quarter-round, step and feed-forward counters and the control FSM.
// ----------------------------------------------------------------------------
`include "chacha20_stream_xor_unit_defines.svh"

module ccx_seq
  import ccx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start_gen,
  input  logic  start_emit,
  input  logic  out_free,
  output ctrl_t ctrl,
  output stat_t stat
);

  localparam int DR_W = $clog2(DOUBLE_ROUNDS);
  localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

  seq_state_t      state_r;
  seq_state_t      state_nxt;
  logic [1:0]      step_r;
  logic [1:0]      step_nxt;
  logic [2:0]      qr_r;
  logic [2:0]      qr_nxt;
  logic [DR_W-1:0] dr_r;
  logic [DR_W-1:0] dr_nxt;
  logic [3:0]      ff_r;
  logic [3:0]      ff_nxt;
  logic            round_done;

  assign round_done = (step_r == 2'd3) && (qr_r == 3'd7) && (dr_r == DR_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start_gen) begin
          state_nxt = SEQ_ROUND;
        end else if (start_emit) begin
          state_nxt = SEQ_EMIT;
        end
      end
      SEQ_ROUND: begin
        if (round_done) begin
          state_nxt = SEQ_FEED;
        end
      end
      SEQ_FEED: begin
        if (ff_r == 4'd15) begin
          state_nxt = SEQ_EMIT;
        end
      end
      SEQ_EMIT: begin
        if (out_free) begin
          state_nxt = SEQ_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.load    = (state_r == SEQ_IDLE) && start_gen;
    ctrl.step_en = (state_r == SEQ_ROUND);
    ctrl.step    = step_r;
    ctrl.ff_en   = (state_r == SEQ_FEED);
    ctrl.ff_idx  = ff_r;
    ctrl.perm    = PERM_NONE;
    if ((state_r == SEQ_ROUND) && (step_r == 2'd3)) begin
      if (qr_r == 3'd3) begin
        ctrl.perm = PERM_DIAG;
      end else if (qr_r == 3'd7) begin
        ctrl.perm = PERM_UNDIAG;
      end else begin
        ctrl.perm = PERM_ROW;
      end
    end
    stat.idle = (state_r == SEQ_IDLE);
    stat.emit = (state_r == SEQ_EMIT) && out_free;
  end

  always_comb begin
    step_nxt = step_r;
    qr_nxt   = qr_r;
    dr_nxt   = dr_r;
    ff_nxt   = ff_r;
    if (state_r == SEQ_ROUND) begin
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        qr_nxt = qr_r + 3'd1;
        if (qr_r == 3'd7) begin
          dr_nxt = (dr_r == DR_LAST) ? '0 : dr_r + DR_W'(1);
        end
      end
    end
    if (state_r == SEQ_FEED) begin
      ff_nxt = ff_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      step_r  <= '0;
      qr_r    <= '0;
      dr_r    <= '0;
      ff_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      qr_r    <= qr_nxt;
      dr_r    <= dr_nxt;
      ff_r    <= ff_nxt;
    end
  end

  `CCX_ASSERT_IMPL(a_feed_counters_wrapped, clk, rst_n, state_r == SEQ_FEED, (step_r == 2'd0) && (qr_r == 3'd0) && (dr_r == '0), "round counters not wrapped at feed-forward")
  `CCX_ASSERT_IMPL(a_ff_idle_zero, clk, rst_n, state_r != SEQ_FEED, ff_r == 4'd0, "feed-forward count left non-zero")
  `CCX_ASSERT_ALWAYS(a_ctrl_exclusive, clk, rst_n, !(ctrl.step_en && ctrl.ff_en) && !(ctrl.load && (ctrl.step_en || ctrl.ff_en)), "overlapping state register controls")

endmodule

@@ bench/chacha20_stream_xor_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_xor_unit_tb
// Self-checking bench for the byte-wise ChaCha20 XOR unit. A behavioural
// cipher model predicts each result word from the bytes and register writes
// that the bench issues; a monitor compares every result word against the
// oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_unit_tb
  import ccx_pkg::*;
();

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int DOUBLE_ROUNDS  = 10;
  // The slowest word opens a new block and waits for all rounds and the feed-forward.
  // Add the longest sender gap and receiver stall and take it several times over.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_BYTES   = 300;
  localparam int PHASE_BYTES    = 70;

  // The index port is three bits wide, so one code is left over; writes to it
  // must not disturb any register.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ccx_in_if  in_ch ();
  ccx_out_if out_ch ();

  chacha20_stream_xor_unit #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Cipher model. It keeps its own copy of the registers, the running block
  // counter, the offset within the current 64-byte block and the keystream
  // block in use.
  // --------------------------------------------------------------------------
  logic [63:0]      key_reg [4];
  logic [63:0]      nonce_lo;
  logic [31:0]      nonce_hi;
  logic [31:0]      init_cnt;
  logic [31:0]      blk_cnt;
  logic [POS_W-1:0] byte_pos;
  block_t           cur_block;

  result_t pending_bytes [$];
  result_t exp_r;

  int  fail_cnt     = 0;
  int  bytes_sent   = 0;
  int  results_seen = 0;
  int  cfg_writes   = 0;
  int  blocks_made  = 0;
  int  messages     = 0;
  int  stall_cycles = 0;
  int  stall_left   = 0;
  bit  in_gap_en    = 1'b0;
  bit  out_stall_en = 1'b0;

  function automatic word_t rol32(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t quarter_round(block_t s, int a, int b, int c, int d);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
    return s;
  endfunction

  // One keystream block for the given counter and the current key and nonce.
  function automatic block_t keystream_block(logic [31:0] ctr);
    block_t init_s;
    block_t x;
    init_s[0]  = SIGMA0;
    init_s[1]  = SIGMA1;
    init_s[2]  = SIGMA2;
    init_s[3]  = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      init_s[4 + 2*k] = key_reg[k][31:0];
      init_s[5 + 2*k] = key_reg[k][63:32];
    end
    init_s[12] = ctr;
    init_s[13] = nonce_lo[31:0];
    init_s[14] = nonce_lo[63:32];
    init_s[15] = nonce_hi;
    x = init_s;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      x = quarter_round(x, 0, 4, 8, 12);
      x = quarter_round(x, 1, 5, 9, 13);
      x = quarter_round(x, 2, 6, 10, 14);
      x = quarter_round(x, 3, 7, 11, 15);
      x = quarter_round(x, 0, 5, 10, 15);
      x = quarter_round(x, 1, 6, 11, 12);
      x = quarter_round(x, 2, 7, 8, 13);
      x = quarter_round(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < NUM_WORDS; i++) x[i] = x[i] + init_s[i];
    return x;
  endfunction

  // Enciphers one message byte and advances the message position.
  function automatic result_t cipher_byte(logic [7:0] data, logic last);
    result_t r;
    if (byte_pos == '0) begin
      cur_block = keystream_block(blk_cnt);
      blocks_made++;
    end
    r.data = data ^ cur_block[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8];
    r.last = last;
    byte_pos = byte_pos + 1'b1;
    if (byte_pos == '0) blk_cnt = blk_cnt + 32'd1;
    if (last) begin
      byte_pos = '0;
      blk_cnt  = init_cnt;
    end
    return r;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_KEY0:     key_reg[0] = data;
      CFG_KEY1:     key_reg[1] = data;
      CFG_KEY2:     key_reg[2] = data;
      CFG_KEY3:     key_reg[3] = data;
      CFG_NONCE_LO: nonce_lo   = data;
      CFG_NONCE_HI: nonce_hi   = data[31:0];
      CFG_INIT_CNT: begin
        init_cnt = data[31:0];
        blk_cnt  = data[31:0];
        byte_pos = '0;
      end
      default: ;
    endcase
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor and receiver. Every accepted result word is checked against
  // the oldest prediction; ready is then redrawn for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_bytes.size() == 0) begin
        $error("result word with nothing expected: out_byte %02h out_last %0b",
               out_ch.out_byte, out_ch.out_last);
        fail_cnt++;
      end else begin
        exp_r = pending_bytes.pop_front();
        if (out_ch.out_byte !== exp_r.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", exp_r.data, out_ch.out_byte);
          fail_cnt++;
        end
        if (out_ch.out_last !== exp_r.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", exp_r.last, out_ch.out_last);
          fail_cnt++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_stall_en) stall_left <= pick_gap();
    end
  end

  // Watchdog: counts cycles in which work is outstanding but neither channel
  // moves a word. Idle periods of the bench itself are not counted.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_bytes.size() == 0 && !in_ch.valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("chacha20_stream_xor_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers. Every task is entered at a rising edge and leaves at one.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = in_gap_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // With no gap, valid simply stays high from the previous word.
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= data;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_bytes.push_back(cipher_byte(data, last));
    bytes_sent++;
  endtask

  task automatic send_message(input int len, input bit with_last);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), with_last && (i == len - 1));
    end
    if (with_last) messages++;
  endtask

  // Drops valid and waits until every predicted word has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Registers are only written while the unit is idle, so the model can take
  // the new value at once.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_config(idx, data);
    cfg_writes++;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Registers still at their reset values: all-zero key, nonce and counter.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    messages++;
    wait_drained();
  endtask

  // Key and nonce of the published block function example, counter one. The
  // model's own first keystream word is checked against the published value
  // before the unit is exercised with it.
  task automatic test_published_vector();
    block_t kat;
    cfg_write(CFG_KEY0, 64'h0706_0504_0302_0100);
    cfg_write(CFG_KEY1, 64'h0F0E_0D0C_0B0A_0908);
    cfg_write(CFG_KEY2, 64'h1716_1514_1312_1110);
    cfg_write(CFG_KEY3, 64'h1F1E_1D1C_1B1A_1918);
    cfg_write(CFG_NONCE_LO, 64'h4A00_0000_0900_0000);
    cfg_write(CFG_NONCE_HI, 64'h0);
    cfg_write(CFG_INIT_CNT, 64'h1);
    kat = keystream_block(32'd1);
    if (kat[0] !== 32'hE4E7_F110) begin
      $error("keystream word 0 mismatch: expected e4e7f110, actual %08h", kat[0]);
      fail_cnt++;
    end
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h7F, 1'b1);
    messages++;
    wait_drained();
  endtask

  // Bits above a register's width are dropped, and the spare index is ignored.
  task automatic test_wide_values_and_spare_index();
    cfg_write(CFG_NONCE_HI, 64'hDEAD_BEEF_0000_0001);
    cfg_write(CFG_INIT_CNT, 64'hFFFF_FFFF_0000_0002);
    cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    messages++;
    wait_drained();
  endtask

  // A key and nonce write in the middle of a block must leave the rest of that
  // block alone and take effect from the next block on.
  task automatic test_key_change_mid_block();
    cfg_write(CFG_INIT_CNT, 64'h10);
    send_message(30, 1'b0);
    wait_drained();
    cfg_write(CFG_KEY2, {$urandom, $urandom});
    cfg_write(CFG_NONCE_LO, {$urandom, $urandom});
    send_message(50, 1'b1);
    wait_drained();
  endtask

  // A message long enough to carry the block counter across its wrap, then a
  // counter write in mid-message, which starts a new message at once.
  task automatic test_counter_wrap_and_restart();
    cfg_write(CFG_INIT_CNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_message(130, 1'b1);
    send_message(10, 1'b0);
    wait_drained();
    cfg_write(CFG_INIT_CNT, 64'h0000_0000_8000_0000);
    send_message(5, 1'b1);
    wait_drained();
  endtask

  // Phases of random messages under changing settings and idling patterns.
  task automatic test_random_traffic();
    int rand_bytes;
    int phase;
    int phase_bytes;
    int len;
    int r;
    bit paused;
    rand_bytes = 0;
    phase      = 0;
    paused     = 1'b0;
    while (rand_bytes < RANDOM_BYTES) begin
      wait_drained();
      // Phase 0 runs with no idling; later ones idle sender, receiver or both.
      in_gap_en    = (phase % 3) != 0;
      out_stall_en = (phase % 4) != 0;
      if (phase == 0) begin
        for (int i = 0; i < 7; i++) cfg_write(cfg_idx_t'(i), '0);
      end else if (phase == 1) begin
        for (int i = 0; i < 7; i++) cfg_write(cfg_idx_t'(i), '1);
      end else begin
        for (int i = 0; i < 7; i++) begin
          if ($urandom_range(0, 1) == 1) begin
            if (i == CFG_INIT_CNT && $urandom_range(0, 1) == 1)
              cfg_write(cfg_idx_t'(i), 64'(32'hFFFF_FFFF - $urandom_range(0, 2)));
            else
              cfg_write(cfg_idx_t'(i), {$urandom, $urandom});
          end
        end
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 24);
        else if (r < 92) len = $urandom_range(25, 70);
        else             len = $urandom_range(71, 140);
        // The closing message of a phase is sometimes left open, so that the
        // next phase's writes land with a block partly used.
        send_message(len, (phase_bytes + len < PHASE_BYTES) || ($urandom_range(0, 99) < 85));
        phase_bytes += len;
        // Hold the sender once until the unit has returned everything.
        if (!paused && phase == 3) begin
          paused = 1'b1;
          wait_drained();
        end
      end
      rand_bytes += phase_bytes;
      phase++;
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= '0;
    in_ch.last_byte <= 1'b0;
    for (int k = 0; k < 4; k++) key_reg[k] = '0;
    nonce_lo  = '0;
    nonce_hi  = '0;
    init_cnt  = '0;
    blk_cnt   = '0;
    byte_pos  = '0;
    cur_block = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_en    = 1'b1;
    out_stall_en = 1'b1;
    test_reset_defaults();
    test_published_vector();
    test_wide_values_and_spare_index();
    test_key_change_mid_block();
    test_counter_wrap_and_restart();
    test_random_traffic();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d message bytes in %0d closed messages, %0d keystream blocks,",
             bytes_sent, messages, blocks_made);
    $display("and %0d register writes; %0d result words were checked.",
             cfg_writes, results_seen);
    if (fail_cnt == 0 && pending_bytes.size() == 0) begin
      $display("chacha20_stream_xor_unit verification clean");
    end else begin
      if (pending_bytes.size() != 0)
        $error("%0d expected result words never arrived", pending_bytes.size());
      $display("chacha20_stream_xor_unit verification failed");
    end
    $finish;
  end

endmodule
